>>> design/tig_pkg.sv
// Shared types and constants for the triangle index generator.
package tig_pkg;

    localparam int INDEX_WIDTH = 32;
    localparam int COUNT_WIDTH = 32;
    localparam int DATA_WIDTH  = 32;
    localparam int CFG_IDX_W   = 2;
    localparam int STEP_W      = 3;

    // Position of the last index within a primitive.
    localparam logic [STEP_W-1:0] TRI_LAST_STEP  = STEP_W'(2);
    localparam logic [STEP_W-1:0] QUAD_LAST_STEP = STEP_W'(5);

    typedef enum logic [1:0] {
        MODE_NONE  = 2'd0,
        MODE_STRIP = 2'd1,
        MODE_FAN   = 2'd2,
        MODE_QUAD  = 2'd3
    } t_prim_mode;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PRIM_MODE    = 2'd0,
        CFG_FIRST_VERTEX = 2'd1,
        CFG_VERTEX_TOTAL = 2'd2
    } t_cfg_reg;

    // One primitive to be expanded into indices.
    typedef struct packed {
        t_prim_mode             mode;
        logic                   odd;
        logic                   last;
        logic [INDEX_WIDTH-1:0] first;
        logic [INDEX_WIDTH-1:0] base;
    } t_prim_cmd;

    typedef struct packed {
        logic      valid;
        t_prim_cmd cmd;
    } t_cmd_req;

endpackage

>>> design/triangle_index_generator_top.sv
// Top level of the triangle index generator: configuration, front end, queue, back end.
//
// Usage:
// The configuration channel writes the primitive mode (index 0), the first vertex
// (index 1) and the vertex count (index 2). Writes are always taken; write only
// while the block is idle. Indexes beyond the list are ignored.
// Each request on the input channel asks for the next primitive of the draw.
// A request with restart set starts the draw over from the first primitive.
// The block answers a request with three indices for a strip or fan triangle,
// six for a quad, or none when the mode is none or the draw is exhausted.
// Each result carries the index and flags for the end of the primitive and the
// end of the draw.
// A request passes through the command queue and the output register before its
// first index appears. The back end emits one index per cycle while the receiver is
// ready; that expander sets the sustained rate. The front end accepts a request every
// cycle while the two-entry command queue has room.
// When the receiver stalls, the output register holds its index, the queue
// fills and then input ready drops. Reset clears the configuration to zero,
// the primitive counter, the queue and the output valid.
module triangle_index_generator_top (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [tig_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [tig_pkg::DATA_WIDTH-1:0]     i_cfg_data,
    input  logic                               i_in_valid,
    output logic                               o_in_ready,
    input  logic                               i_restart,
    output logic                               o_out_valid,
    input  logic                               i_out_ready,
    output logic [tig_pkg::INDEX_WIDTH-1:0]    o_vertex_index,
    output logic                               o_prim_end,
    output logic                               o_draw_end
);
    import tig_pkg::*;

    t_prim_mode             r_prim_mode;
    logic [DATA_WIDTH-1:0]  r_first_vertex;
    logic [DATA_WIDTH-1:0]  r_vertex_total;
    t_cmd_req               push;
    t_cmd_req               head;
    logic                   q_full;
    logic                   pop;

    // Configuration writes complete in the cycle they are presented.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prim_mode    <= MODE_NONE;
            r_first_vertex <= '0;
            r_vertex_total <= '0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_PRIM_MODE:    r_prim_mode    <= t_prim_mode'(i_cfg_data[1:0]);
                CFG_FIRST_VERTEX: r_first_vertex <= i_cfg_data;
                CFG_VERTEX_TOTAL: r_vertex_total <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // The front end decides whether a request yields a primitive and
    // computes its base index.
    tig_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_prim_mode    (r_prim_mode),
        .i_first_vertex (r_first_vertex),
        .i_vertex_total (r_vertex_total),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_restart      (i_restart),
        .i_q_full       (q_full),
        .o_push         (push)
    );

    // The queue decouples request intake from index emission.
    tig_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .o_full  (q_full),
        .o_head  (head),
        .i_pop   (pop)
    );

    // The back end walks each primitive one index per cycle into the
    // output register while the receiver is ready.
    tig_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_head         (head),
        .o_pop          (pop),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_vertex_index (o_vertex_index),
        .o_prim_end     (o_prim_end),
        .o_draw_end     (o_draw_end)
    );

endmodule

>>> design/tig_front.sv
// Front end: accepts requests, tracks the primitive counter and classifies each primitive.
module tig_front (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  tig_pkg::t_prim_mode                i_prim_mode,
    input  logic [tig_pkg::DATA_WIDTH-1:0]     i_first_vertex,
    input  logic [tig_pkg::DATA_WIDTH-1:0]     i_vertex_total,
    input  logic                               i_in_valid,
    output logic                               o_in_ready,
    input  logic                               i_restart,
    input  logic                               i_q_full,
    output tig_pkg::t_cmd_req                  o_push
);
    import tig_pkg::*;

    logic [COUNT_WIDTH-1:0] r_counter, n_counter;
    logic [COUNT_WIDTH-1:0] prim_total;
    logic [COUNT_WIDTH-1:0] prim_total_m1;
    logic [COUNT_WIDTH-1:0] k;
    logic [INDEX_WIDTH-1:0] start;
    logic [INDEX_WIDTH-1:0] step_off;
    logic                   accept;
    logic                   live;

    // Primitive count of the draw as currently configured, and the number of its
    // last primitive, so a request right after a register write sees the new draw.
    always_comb begin
        case (i_prim_mode)
            MODE_STRIP, MODE_FAN: begin
                prim_total    = (i_vertex_total >= COUNT_WIDTH'(3))
                              ? (i_vertex_total - COUNT_WIDTH'(2)) : '0;
                prim_total_m1 = i_vertex_total - COUNT_WIDTH'(3);
            end
            MODE_QUAD: begin
                prim_total    = i_vertex_total >> 2;
                prim_total_m1 = (i_vertex_total >> 2) - COUNT_WIDTH'(1);
            end
            default: begin
                prim_total    = '0;
                prim_total_m1 = '1;
            end
        endcase
    end

    always_comb begin
        o_in_ready = !i_q_full;
        accept     = i_in_valid && !i_q_full;
        k          = i_restart ? '0 : r_counter;
        live       = (i_prim_mode != MODE_NONE) && (k < prim_total);
        start      = i_first_vertex[INDEX_WIDTH-1:0];
        if (i_prim_mode == MODE_QUAD) begin
            step_off = {k[INDEX_WIDTH-3:0], 2'b00};
        end else begin
            step_off = k[INDEX_WIDTH-1:0];
        end
        n_counter = r_counter;
        if (accept) begin
            n_counter = live ? (k + COUNT_WIDTH'(1)) : k;
        end
        o_push.valid     = accept && live;
        o_push.cmd.mode  = i_prim_mode;
        o_push.cmd.odd   = k[0];
        o_push.cmd.last  = (k == prim_total_m1);
        o_push.cmd.first = start;
        o_push.cmd.base  = start + step_off;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_counter <= '0;
        end else begin
            r_counter <= n_counter;
        end
    end

endmodule

>>> design/tig_queue.sv
// Two-entry command queue between the front end and the index expander.
module tig_queue (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  tig_pkg::t_cmd_req   i_push,
    output logic                o_full,
    output tig_pkg::t_cmd_req   o_head,
    input  logic                i_pop
);
    import tig_pkg::*;

    t_prim_cmd   r_mem [2];
    logic        r_wr_ptr, n_wr_ptr;
    logic        r_rd_ptr, n_rd_ptr;
    logic [1:0]  r_count, n_count;
    logic        do_push;
    logic        do_pop;

    always_comb begin
        o_full       = (r_count == 2'd2);
        do_push      = i_push.valid && !o_full;
        do_pop       = i_pop && (r_count != 2'd0);
        o_head.valid = (r_count != 2'd0);
        o_head.cmd   = r_mem[r_rd_ptr];
        n_wr_ptr     = do_push ? !r_wr_ptr : r_wr_ptr;
        n_rd_ptr     = do_pop ? !r_rd_ptr : r_rd_ptr;
        n_count      = r_count + 2'(do_push) - 2'(do_pop);
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_push.cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

endmodule

>>> design/tig_back.sv
// Back end: expands one queued primitive into its indices, one per cycle unless stalled.
module tig_back (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  tig_pkg::t_cmd_req                  i_head,
    output logic                               o_pop,
    output logic                               o_out_valid,
    input  logic                               i_out_ready,
    output logic [tig_pkg::INDEX_WIDTH-1:0]    o_vertex_index,
    output logic                               o_prim_end,
    output logic                               o_draw_end
);
    import tig_pkg::*;

    logic [STEP_W-1:0]      r_step, n_step;
    logic                   r_valid, n_valid;
    logic [INDEX_WIDTH-1:0] r_index, n_index;
    logic                   r_prim_end, n_prim_end;
    logic                   r_draw_end, n_draw_end;
    logic [STEP_W-1:0]      last_step;
    logic [1:0]             offset;
    logic                   advance;
    logic                   at_end;

    // Offset of each index from the primitive's base.
    function automatic logic [1:0] index_offset(t_prim_mode mode, logic odd,
                                                logic [STEP_W-1:0] step);
        logic [1:0] off;
        off = 2'd0;
        case (mode)
            MODE_QUAD: begin
                case (step)
                    3'd1:    off = 2'd1;
                    3'd2:    off = 2'd2;
                    3'd3:    off = 2'd2;
                    3'd4:    off = 2'd1;
                    3'd5:    off = 2'd3;
                    default: off = 2'd0;
                endcase
            end
            default: begin
                // Strip winding swaps the last two vertices on odd triangles.
                case (step)
                    3'd1:    off = (odd && mode == MODE_STRIP) ? 2'd2 : 2'd1;
                    3'd2:    off = (odd && mode == MODE_STRIP) ? 2'd1 : 2'd2;
                    default: off = 2'd0;
                endcase
            end
        endcase
        return off;
    endfunction

    always_comb begin
        last_step = (i_head.cmd.mode == MODE_QUAD) ? QUAD_LAST_STEP : TRI_LAST_STEP;
        offset    = index_offset(i_head.cmd.mode, i_head.cmd.odd, r_step);
        advance   = !r_valid || i_out_ready;
        at_end    = (r_step == last_step);
        o_pop     = advance && i_head.valid && at_end;

        n_step     = r_step;
        n_valid    = r_valid;
        n_index    = r_index;
        n_prim_end = r_prim_end;
        n_draw_end = r_draw_end;
        if (advance) begin
            n_valid = i_head.valid;
            if (i_head.valid) begin
                if (i_head.cmd.mode == MODE_FAN && r_step == '0) begin
                    n_index = i_head.cmd.first;
                end else begin
                    n_index = i_head.cmd.base + INDEX_WIDTH'(offset);
                end
                n_prim_end = at_end;
                n_draw_end = at_end && i_head.cmd.last;
                n_step     = at_end ? '0 : (r_step + STEP_W'(1));
            end
        end

        o_out_valid    = r_valid;
        o_vertex_index = r_index;
        o_prim_end     = r_prim_end;
        o_draw_end     = r_draw_end;
    end

    always_ff @(posedge i_clk) begin
        r_index    <= n_index;
        r_prim_end <= n_prim_end;
        r_draw_end <= n_draw_end;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step  <= '0;
            r_valid <= 1'b0;
        end else begin
            r_step  <= n_step;
            r_valid <= n_valid;
        end
    end

`ifndef SYNTHESIS
    a_draw_end_on_prim_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && r_draw_end) |-> r_prim_end)
        else $error("draw end flagged on an index that does not end a primitive");

    a_step_restarts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |=> (r_step == '0))
        else $error("step counter not cleared after a primitive completed");

    a_step_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_head.valid |-> (r_step <= last_step))
        else $error("step counter ran past the last index of the primitive");
`endif

endmodule

>>> verif/tb_triangle_index_generator_top.sv
// Self-checking testbench for the triangle index generator: directed draws, then random draws.
module tb_triangle_index_generator_top;
    timeunit 1ns;
    timeprecision 1ps;

    import tig_pkg::*;

    // Register index that the block leaves unmapped; a write to it must change nothing.
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

    // Cycles to let pass after the last expected index before touching the registers.
    // This covers a request still in flight that yields no indices at all.
    localparam int SETTLE_CYCLES   = 8;
    // Consecutive cycles without any accepted request, index or register write before giving up.
    localparam int WATCHDOG_LIMIT  = 3000;
    // Random requests to send after the directed draws.
    localparam int RANDOM_REQUESTS = 385;

    // One expected index together with its flags.
    typedef struct {
        logic [INDEX_WIDTH-1:0] vertex;
        logic                   prim_end;
        logic                   draw_end;
    } t_index_exp;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   i_cfg_valid = 1'b0;
    logic                   o_cfg_ready;
    logic [CFG_IDX_W-1:0]   i_cfg_index = '0;
    logic [DATA_WIDTH-1:0]  i_cfg_data = '0;
    logic                   i_in_valid = 1'b0;
    logic                   o_in_ready;
    logic                   i_restart = 1'b0;
    logic                   o_out_valid;
    logic                   i_out_ready = 1'b0;
    logic [INDEX_WIDTH-1:0] o_vertex_index;
    logic                   o_prim_end;
    logic                   o_draw_end;

    triangle_index_generator_top i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_restart      (i_restart),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_vertex_index (o_vertex_index),
        .o_prim_end     (o_prim_end),
        .o_draw_end     (o_draw_end)
    );

    // The clock runs with a 10 ns period.
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Our own copy of the block's registers and primitive counter.
    t_prim_mode             draw_mode = MODE_NONE;
    logic [INDEX_WIDTH-1:0] draw_first = '0;
    logic [COUNT_WIDTH-1:0] draw_total = '0;
    logic [COUNT_WIDTH-1:0] draw_counter = '0;

    // Restart bits of requests still to be sent, and indices still to be received.
    bit         pending_restarts[$];
    t_index_exp expected_indices[$];

    int unsigned fail_count = 0;
    int unsigned requests_queued = 0;
    int unsigned quiet_cycles = 0;
    bit          idling_enabled = 1'b1;
    bit          request_taken = 1'b0;
    int unsigned send_gap = 0;
    int unsigned stall_left = 0;

    // Gap length for either side: mostly none or short, now and then long.
    // With idling switched off for a phase the traffic runs back to back.
    function automatic int unsigned pick_gap();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (!idling_enabled || roll < 55) begin
            return 0;
        end
        if (roll < 90) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 40);
    endfunction

    // Number of primitives in the configured draw. A strip or fan with fewer than
    // three vertices has none, and quads drop the leftover vertices.
    function automatic logic [COUNT_WIDTH-1:0] primitives_in_draw();
        case (draw_mode)
            MODE_STRIP, MODE_FAN: begin
                return (draw_total >= 3) ? draw_total - 2 : '0;
            end
            MODE_QUAD: begin
                return draw_total >> 2;
            end
            default: begin
                return '0;
            end
        endcase
    endfunction

    // Works out the indices one request yields and queues them. The counter
    // stays put when nothing is emitted (mode none or an exhausted draw).
    function automatic void expand_primitive(input logic restart);
        logic [COUNT_WIDTH-1:0] prims;
        logic [INDEX_WIDTH-1:0] k;
        logic [INDEX_WIDTH-1:0] base;
        logic [INDEX_WIDTH-1:0] vtx[6];
        logic                   last_prim;
        int                     count;
        t_index_exp             entry;
        if (restart) begin
            draw_counter = '0;
        end
        prims = primitives_in_draw();
        if (draw_mode == MODE_NONE || draw_counter >= prims) begin
            return;
        end
        k = draw_counter;
        case (draw_mode)
            MODE_STRIP: begin
                // Odd triangles swap their last two vertices to keep the winding.
                vtx[0] = draw_first + k;
                vtx[1] = draw_first + k + 1 + {31'b0, k[0]};
                vtx[2] = draw_first + k + 2 - {31'b0, k[0]};
                count  = 3;
            end
            MODE_FAN: begin
                vtx[0] = draw_first;
                vtx[1] = draw_first + k + 1;
                vtx[2] = draw_first + k + 2;
                count  = 3;
            end
            default: begin
                base   = draw_first + (k << 2);
                vtx[0] = base;
                vtx[1] = base + 1;
                vtx[2] = base + 2;
                vtx[3] = base + 2;
                vtx[4] = base + 1;
                vtx[5] = base + 3;
                count  = 6;
            end
        endcase
        last_prim = (draw_counter + 1) == prims;
        for (int i = 0; i < count; i++) begin
            entry.vertex   = vtx[i];
            entry.prim_end = (i == count - 1);
            entry.draw_end = (i == count - 1) && last_prim;
            expected_indices.push_back(entry);
        end
        draw_counter++;
    endfunction

    // Register write as the block sees it. Only the low two bits of the mode count.
    function automatic void apply_register(input logic [CFG_IDX_W-1:0] index,
                                           input logic [DATA_WIDTH-1:0] data);
        case (index)
            CFG_PRIM_MODE:    draw_mode = t_prim_mode'(data[1:0]);
            CFG_FIRST_VERTEX: draw_first = data;
            CFG_VERTEX_TOTAL: draw_total = data;
            default: ;
        endcase
    endfunction

    // Request tracking: every accepted register write and every accepted request
    // updates our copy of the block at the same edge that the block sees it.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_cfg_valid && o_cfg_ready) begin
                apply_register(i_cfg_index, i_cfg_data);
            end
            if (i_in_valid && o_in_ready) begin
                expand_primitive(i_restart);
                request_taken = 1'b1;
            end
        end
    end

    // Request driver. A request stays up, unchanged, until the edge that takes it;
    // only then may a gap follow or the next request go out.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (!i_in_valid || request_taken) begin
            request_taken = 1'b0;
            if (send_gap != 0) begin
                send_gap--;
                i_in_valid <= 1'b0;
            end else if (pending_restarts.size() != 0) begin
                i_restart  <= pending_restarts.pop_front();
                i_in_valid <= 1'b1;
                send_gap = pick_gap();
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // Receiver back-pressure: stalls start at random points, so they land on any
    // index of a primitive, not only on the first.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else if (stall_left != 0) begin
            stall_left--;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= 1'b1;
            if ($urandom_range(0, 3) == 0) begin
                stall_left = pick_gap();
            end
        end
    end

    // Index monitor and watchdog. Each accepted index is checked against the
    // oldest expectation, field by field.
    always @(posedge i_clk) begin
        t_index_exp want;
        if (i_rst_n) begin
            if (o_out_valid && i_out_ready) begin
                if (expected_indices.size() == 0) begin
                    $error("unexpected index %h (prim_end %b draw_end %b)",
                           o_vertex_index, o_prim_end, o_draw_end);
                    fail_count++;
                end else begin
                    want = expected_indices.pop_front();
                    if (o_vertex_index !== want.vertex) begin
                        $error("vertex_index: expected %h, got %h", want.vertex, o_vertex_index);
                        fail_count++;
                    end
                    if (o_prim_end !== want.prim_end) begin
                        $error("prim_end: expected %b, got %b", want.prim_end, o_prim_end);
                        fail_count++;
                    end
                    if (o_draw_end !== want.draw_end) begin
                        $error("draw_end: expected %b, got %b", want.draw_end, o_draw_end);
                        fail_count++;
                    end
                end
            end
            if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) ||
                (i_cfg_valid && o_cfg_ready)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
            end
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("TB_ERROR");
                $finish;
            end
        end
    end

    // One register write on the configuration channel, held until taken.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] index,
                             input logic [DATA_WIDTH-1:0] data);
        @(negedge i_clk);
        i_cfg_index <= index;
        i_cfg_data  <= data;
        i_cfg_valid <= 1'b1;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // Waits until every request is out and every expected index has arrived, then
    // lets the pipeline settle so that a request yielding nothing is finished too.
    task automatic wait_idle();
        do @(posedge i_clk);
        while (pending_restarts.size() != 0 || i_in_valid || expected_indices.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic queue_requests(input int unsigned count, input bit first_restart,
                                  input int unsigned restart_pct);
        for (int unsigned i = 0; i < count; i++) begin
            if (i == 0) begin
                pending_restarts.push_back(first_restart);
            end else begin
                pending_restarts.push_back($urandom_range(0, 99) < restart_pct);
            end
        end
        requests_queued += count;
    endtask

    initial begin
        int unsigned draw_len;
        int unsigned roll;
        t_prim_mode  pick_mode;
        logic [COUNT_WIDTH-1:0] prims;

        // Synchronous reset, released on a falling edge.
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Straight out of reset the mode is none: requests, with or without
        // restart, yield nothing.
        pending_restarts = '{1'b0, 1'b1};
        wait_idle();

        // Five-vertex strip: three triangles with alternating winding, then an
        // exhausted request, then a restart back to the first triangle. The mode
        // data carries junk in its upper bits, which must be dropped.
        write_reg(CFG_PRIM_MODE, 32'hFFFF_FFFD);
        write_reg(CFG_FIRST_VERTEX, 32'h0000_0000);
        write_reg(CFG_VERTEX_TOTAL, 32'd5);
        pending_restarts = '{1'b0, 1'b0, 1'b0, 1'b0, 1'b1};
        wait_idle();

        // Strip too short to hold a triangle: no indices, no wrapped loop.
        write_reg(CFG_VERTEX_TOTAL, 32'd2);
        pending_restarts = '{1'b1, 1'b0};
        wait_idle();

        // Fan anchored just below the top of the index range, so indices wrap.
        write_reg(CFG_PRIM_MODE, 32'(MODE_FAN));
        write_reg(CFG_FIRST_VERTEX, 32'hFFFF_FFFE);
        write_reg(CFG_VERTEX_TOTAL, 32'd6);
        pending_restarts = '{1'b1, 1'b0, 1'b0, 1'b0, 1'b0};
        wait_idle();

        // Quads over nine vertices: two quads, the ninth vertex is left over, and
        // the third request finds the draw exhausted.
        write_reg(CFG_PRIM_MODE, 32'(MODE_QUAD));
        write_reg(CFG_FIRST_VERTEX, 32'hFFFF_FFF8);
        write_reg(CFG_VERTEX_TOTAL, 32'd9);
        pending_restarts = '{1'b1, 1'b0, 1'b0};
        wait_idle();

        // An empty draw, and a write to the unmapped register that must not disturb
        // anything.
        write_reg(CFG_VERTEX_TOTAL, 32'h0000_0000);
        write_reg(CFG_SPARE, 32'hFFFF_FFFF);
        pending_restarts = '{1'b1};
        wait_idle();

        // Largest vertex count with the largest first vertex, then a new first
        // vertex mid-draw without restart: the counter carries on.
        write_reg(CFG_PRIM_MODE, 32'(MODE_STRIP));
        write_reg(CFG_FIRST_VERTEX, 32'hFFFF_FFFF);
        write_reg(CFG_VERTEX_TOTAL, 32'hFFFF_FFFF);
        pending_restarts = '{1'b1, 1'b0, 1'b0, 1'b0};
        wait_idle();
        write_reg(CFG_FIRST_VERTEX, 32'h1234_0000);
        pending_restarts = '{1'b0, 1'b0};
        wait_idle();

        // Random draws. Most phases are a draw started by a restart and run to or
        // past its end with random registers; some are noise with random restarts.
        // Registers are left alone now and then so that a draw can resume.
        while (requests_queued < RANDOM_REQUESTS) begin
            idling_enabled = ($urandom_range(0, 3) != 0);
            if ($urandom_range(0, 3) != 0) begin
                roll = $urandom_range(0, 9);
                pick_mode = (roll == 0) ? MODE_NONE : t_prim_mode'($urandom_range(1, 3));
                write_reg(CFG_PRIM_MODE, ($urandom() & 32'hFFFF_FFFC) | 32'(pick_mode));
            end
            if ($urandom_range(0, 3) != 0) begin
                roll = $urandom_range(0, 7);
                if (roll < 2) begin
                    write_reg(CFG_FIRST_VERTEX, 32'hFFFF_FFFF - $urandom_range(0, 30));
                end else if (roll == 2) begin
                    write_reg(CFG_FIRST_VERTEX, 32'h0000_0000);
                end else begin
                    write_reg(CFG_FIRST_VERTEX, $urandom());
                end
            end
            if ($urandom_range(0, 3) != 0) begin
                roll = $urandom_range(0, 9);
                if (roll < 8) begin
                    write_reg(CFG_VERTEX_TOTAL, $urandom_range(0, 24));
                end else if (roll == 8) begin
                    write_reg(CFG_VERTEX_TOTAL, $urandom_range(0, 2));
                end else begin
                    write_reg(CFG_VERTEX_TOTAL, $urandom() | 32'h8000_0000);
                end
            end
            prims = primitives_in_draw();
            if ($urandom_range(0, 9) == 0) begin
                queue_requests($urandom_range(1, 10), $urandom_range(0, 1), 50);
            end else begin
                if (prims > 24) begin
                    draw_len = $urandom_range(4, 24);
                end else begin
                    draw_len = prims + $urandom_range(1, 2);
                end
                queue_requests(draw_len, $urandom_range(0, 99) < 85, 5);
            end
            wait_idle();
        end

        // Every request is answered and the pipeline has settled.
        if (fail_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
